// ===== design/hpd_pkg.sv =====
// Shared constants, register indexes and types of the heading PID drive.
`timescale 1ns / 1ps

package hpd_pkg;

    localparam int INTEG_W = 32;

    localparam int MAG_W = 28;
    localparam int Q_W = 18;
    localparam int A_W = (INTEG_W > MAG_W + 1) ? INTEG_W : MAG_W + 1;
    localparam int B_W = 30;
    localparam int P_W = A_W + B_W;
    localparam int ACC_W = ((INTEG_W > Q_W + 1) ? INTEG_W : Q_W + 1) + 1;
    localparam int SUM_W = INTEG_W + 18;
    localparam int DRV_W = SUM_W - 8;

    localparam int RECIP_SH = 38;
    localparam logic [B_W-1:0] RECIP = B_W'(274877906);
    localparam logic [B_W-1:0] DIV_K = B_W'(1000);

    localparam logic signed [ACC_W-1:0] IMAX =
        {{(ACC_W - INTEG_W + 1){1'b0}}, {(INTEG_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] IMIN =
        {{(ACC_W - INTEG_W + 1){1'b1}}, {(INTEG_W - 1){1'b0}}};

    localparam logic [2:0] CFG_TARGET    = 3'd0;
    localparam logic [2:0] CFG_GAIN_P    = 3'd1;
    localparam logic [2:0] CFG_GAIN_D    = 3'd2;
    localparam logic [2:0] CFG_GAIN_I    = 3'd3;
    localparam logic [2:0] CFG_MIN_DRIVE = 3'd4;
    localparam logic [2:0] CFG_MAX_DRIVE = 3'd5;
    localparam logic [2:0] CFG_MAX_SPEED = 3'd6;

    typedef struct packed {
        logic           en;
        logic [A_W-1:0] a;
        logic [B_W-1:0] b;
    } mul_req_t;

endpackage

// ===== design/hpd_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module hpd_mul (
    input  logic                            aclk,
    input  hpd_pkg::mul_req_t               req,
    output logic signed [hpd_pkg::P_W-1:0]  prod_reg
);

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= $signed(req.a) * $signed(req.b);
        end
    end

endmodule

// ===== design/heading_pid_drive.sv =====
// Top level of the heading PID drive: configuration, sequencer and output register.
`timescale 1ns / 1ps

// Heading-hold PID drive. Each accepted transaction carries a gyro heading code
// (two degrees per step) and the microseconds since the previous code; one result
// follows with the wrapped heading error, the deadband flag and the signed drive.
// After an item is accepted, s_ready stays low until the sequencer is back in idle, so
// a new item waits until the last is done. The reason is that all six products (error
// times elapsed time, the reciprocal division by 1000 and its check, and the three
// gain terms) go one after another through a single registered multiplier. The last
// step moves the result into an output register and waits while that register still
// holds a result that m_ready has not taken; once it has moved, the next item may be
// accepted while the result waits for m_ready.
module heading_pid_drive (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_heading_code,
    input  logic [19:0]         s_elapsed_us,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [10:0]  m_drive,
    output logic signed [8:0]   m_heading_error,
    output logic                m_in_deadband,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EMUL  = 4'd1;
    localparam logic [3:0] ST_RMUL  = 4'd2;
    localparam logic [3:0] ST_QMUL  = 4'd3;
    localparam logic [3:0] ST_FIX   = 4'd4;
    localparam logic [3:0] ST_DMUL  = 4'd5;
    localparam logic [3:0] ST_IMUL  = 4'd6;
    localparam logic [3:0] ST_SUM   = 4'd7;
    localparam logic [3:0] ST_SCALE = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0]  state_reg, state_next;

    logic [8:0]  target_reg;
    logic [15:0] gain_p_reg;
    logic [15:0] gain_d_reg;
    logic [15:0] gain_i_reg;
    logic [9:0]  min_drive_reg;
    logic [9:0]  max_drive_reg;
    logic [9:0]  max_speed_reg;

    logic signed [8:0]                  err_reg;
    logic [19:0]                        elapsed_reg;
    logic signed [9:0]                  prev_err_reg;
    logic signed [hpd_pkg::INTEG_W-1:0] integral_reg;
    logic [hpd_pkg::MAG_W-1:0]          mag_reg;
    logic                               neg_reg;
    logic [hpd_pkg::Q_W-1:0]            q_reg;
    logic signed [hpd_pkg::SUM_W-1:0]   sum_reg;
    logic signed [hpd_pkg::DRV_W-1:0]   drv_reg;

    logic                m_valid_reg;
    logic signed [10:0]  m_drive_reg;
    logic signed [8:0]   m_heading_error_reg;
    logic                m_in_deadband_reg;

    hpd_pkg::mul_req_t                  mul_req;
    logic signed [hpd_pkg::P_W-1:0]     prod_reg;

    logic signed [10:0]                 raw_err;
    logic signed [10:0]                 wrap_err;
    logic signed [9:0]                  err_diff;
    logic                               prod_neg;
    logic signed [hpd_pkg::P_W-1:0]     prod_abs;
    logic [hpd_pkg::MAG_W-1:0]          rem;
    logic [hpd_pkg::Q_W-1:0]            q_fix;
    logic signed [hpd_pkg::Q_W:0]       q_signed;
    logic signed [hpd_pkg::ACC_W-1:0]   acc;
    logic signed [hpd_pkg::ACC_W-1:0]   acc_sat;
    logic signed [hpd_pkg::SUM_W-1:0]   sum_rnd;
    logic signed [hpd_pkg::DRV_W-1:0]   drv_scaled;
    logic signed [hpd_pkg::DRV_W-1:0]   min_s;
    logic signed [hpd_pkg::DRV_W-1:0]   drv_min;
    logic [9:0]                         lim;
    logic signed [hpd_pkg::DRV_W-1:0]   lim_s;
    logic signed [hpd_pkg::DRV_W-1:0]   drv_clamp;
    logic                               dead;
    logic                               out_free;

    hpd_mul u_mul (
        .aclk     (aclk),
        .req      (mul_req),
        .prod_reg (prod_reg)
    );

    assign s_ready         = aresetn && (state_reg == ST_IDLE);
    assign cfg_ready       = aresetn;
    assign m_valid         = m_valid_reg;
    assign m_drive         = m_drive_reg;
    assign m_heading_error = m_heading_error_reg;
    assign m_in_deadband   = m_in_deadband_reg;

    always_comb begin
        raw_err = $signed({2'b00, target_reg}) - $signed({2'b00, s_heading_code, 1'b0});
        if (raw_err > 11'sd180) begin
            wrap_err = raw_err - 11'sd360;
        end else if (raw_err < -11'sd180) begin
            wrap_err = raw_err + 11'sd360;
        end else begin
            wrap_err = raw_err;
        end
    end

    assign err_diff = 10'(err_reg) - prev_err_reg;
    assign prod_neg = prod_reg[hpd_pkg::P_W-1];
    assign prod_abs = prod_neg ? -prod_reg : prod_reg;

    always_comb begin
        rem      = mag_reg - prod_reg[hpd_pkg::MAG_W-1:0];
        q_fix    = (rem >= hpd_pkg::MAG_W'(hpd_pkg::DIV_K)) ? q_reg + 1'b1 : q_reg;
        q_signed = neg_reg ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
        acc      = hpd_pkg::ACC_W'(integral_reg) + hpd_pkg::ACC_W'(q_signed);
        if (acc > hpd_pkg::IMAX) begin
            acc_sat = hpd_pkg::IMAX;
        end else if (acc < hpd_pkg::IMIN) begin
            acc_sat = hpd_pkg::IMIN;
        end else begin
            acc_sat = acc;
        end
    end

    always_comb begin
        sum_rnd    = sum_reg + (sum_reg[hpd_pkg::SUM_W-1] ? hpd_pkg::SUM_W'(255)
                                                          : hpd_pkg::SUM_W'(0));
        drv_scaled = sum_rnd[hpd_pkg::SUM_W-1:8];
        min_s      = $signed(hpd_pkg::DRV_W'(min_drive_reg));
        if (drv_scaled > 0 && drv_scaled < min_s) begin
            drv_min = min_s;
        end else if (drv_scaled < 0 && drv_scaled > -min_s) begin
            drv_min = -min_s;
        end else begin
            drv_min = drv_scaled;
        end
    end

    always_comb begin
        dead  = (err_reg < 9'sd2) && (err_reg > -9'sd2);
        lim   = (max_drive_reg < max_speed_reg) ? max_drive_reg : max_speed_reg;
        lim_s = $signed(hpd_pkg::DRV_W'(lim));
        if (dead) begin
            drv_clamp = '0;
        end else if (drv_reg > lim_s) begin
            drv_clamp = lim_s;
        end else if (drv_reg < -lim_s) begin
            drv_clamp = -lim_s;
        end else begin
            drv_clamp = drv_reg;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        mul_req = '0;
        unique case (state_reg)
            ST_EMUL: begin
                mul_req.en = 1'b1;
                mul_req.a  = hpd_pkg::A_W'(err_reg);
                mul_req.b  = hpd_pkg::B_W'(elapsed_reg);
            end
            ST_RMUL: begin
                mul_req.en = 1'b1;
                mul_req.a  = hpd_pkg::A_W'(prod_abs[hpd_pkg::MAG_W-1:0]);
                mul_req.b  = hpd_pkg::RECIP;
            end
            ST_QMUL: begin
                mul_req.en = 1'b1;
                mul_req.a  = hpd_pkg::A_W'(prod_reg[hpd_pkg::RECIP_SH +: hpd_pkg::Q_W]);
                mul_req.b  = hpd_pkg::DIV_K;
            end
            ST_FIX: begin
                mul_req.en = 1'b1;
                mul_req.a  = hpd_pkg::A_W'(err_reg);
                mul_req.b  = hpd_pkg::B_W'(gain_p_reg);
            end
            ST_DMUL: begin
                mul_req.en = 1'b1;
                mul_req.a  = hpd_pkg::A_W'(err_diff);
                mul_req.b  = hpd_pkg::B_W'(gain_d_reg);
            end
            ST_IMUL: begin
                mul_req.en = 1'b1;
                mul_req.a  = hpd_pkg::A_W'(integral_reg);
                mul_req.b  = hpd_pkg::B_W'(gain_i_reg);
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_EMUL;
            ST_EMUL:  state_next = ST_RMUL;
            ST_RMUL:  state_next = ST_QMUL;
            ST_QMUL:  state_next = ST_FIX;
            ST_FIX:   state_next = ST_DMUL;
            ST_DMUL:  state_next = ST_IMUL;
            ST_IMUL:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= '0;
            gain_p_reg    <= 16'd256;
            gain_d_reg    <= '0;
            gain_i_reg    <= '0;
            min_drive_reg <= '0;
            max_drive_reg <= 10'd255;
            max_speed_reg <= 10'd256;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                hpd_pkg::CFG_TARGET:    target_reg    <= cfg_data[8:0];
                hpd_pkg::CFG_GAIN_P:    gain_p_reg    <= cfg_data;
                hpd_pkg::CFG_GAIN_D:    gain_d_reg    <= cfg_data;
                hpd_pkg::CFG_GAIN_I:    gain_i_reg    <= cfg_data;
                hpd_pkg::CFG_MIN_DRIVE: min_drive_reg <= cfg_data[9:0];
                hpd_pkg::CFG_MAX_DRIVE: max_drive_reg <= cfg_data[9:0];
                hpd_pkg::CFG_MAX_SPEED: max_speed_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            prev_err_reg <= '0;
            integral_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FIX) begin
                integral_reg <= acc_sat[hpd_pkg::INTEG_W-1:0];
            end
            if (state_reg == ST_OUT && out_free) begin
                prev_err_reg <= 10'(err_reg);
                m_valid_reg  <= 1'b1;
                if (dead) begin
                    integral_reg <= '0;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            err_reg     <= wrap_err[8:0];
            elapsed_reg <= s_elapsed_us;
        end
        if (state_reg == ST_RMUL) begin
            mag_reg <= prod_abs[hpd_pkg::MAG_W-1:0];
            neg_reg <= prod_neg;
        end
        if (state_reg == ST_QMUL) begin
            q_reg <= prod_reg[hpd_pkg::RECIP_SH +: hpd_pkg::Q_W];
        end
        if (state_reg == ST_DMUL) begin
            sum_reg <= prod_reg[hpd_pkg::SUM_W-1:0];
        end
        if (state_reg == ST_IMUL || state_reg == ST_SUM) begin
            sum_reg <= sum_reg + prod_reg[hpd_pkg::SUM_W-1:0];
        end
        if (state_reg == ST_SCALE) begin
            drv_reg <= drv_min;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_drive_reg         <= drv_clamp[10:0];
            m_heading_error_reg <= err_reg;
            m_in_deadband_reg   <= dead;
        end
    end

`ifndef SYNTHESIS
    a_dead_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_in_deadband) |-> (m_drive == 11'sd0))
        else $error("Drive is nonzero inside the deadband.");

    a_dead_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_in_deadband) |->
        ($signed(m_heading_error) >= 9'sd2 || $signed(m_heading_error) <= -9'sd2))
        else $error("Deadband flag disagrees with the heading error.");

    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_heading_error) <= 9'sd180 &&
                     $signed(m_heading_error) >= -9'sd180))
        else $error("Heading error is outside the wrapped range.");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("A new transaction was taken while one is in progress.");
`endif

endmodule

// ===== dv/heading_pid_drive_tb.sv =====
// Self-checking testbench of the heading PID drive: directed cases, integral windup and random traffic.
`timescale 1ns / 1ps

module heading_pid_drive_tb;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic signed [10:0] drive;
        logic signed [8:0]  heading_error;
        logic               in_deadband;
    } drive_res_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_heading_code = '0;
    logic [19:0]        s_elapsed_us = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [10:0] m_drive;
    logic signed [8:0]  m_heading_error;
    logic               m_in_deadband;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    logic [8:0]  cfg_target = 9'd0;
    logic [15:0] cfg_kp = 16'd256;
    logic [15:0] cfg_kd = 16'd0;
    logic [15:0] cfg_ki = 16'd0;
    logic [9:0]  cfg_min = 10'd0;
    logic [9:0]  cfg_max_drive = 10'd255;
    logic [9:0]  cfg_max_speed = 10'd256;
    longint      prev_error = 0;
    longint      integ_sum = 0;

    drive_res_t  pending_results[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    bit          steady = 1'b0;

    heading_pid_drive dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_heading_code  (s_heading_code),
        .s_elapsed_us    (s_elapsed_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive         (m_drive),
        .m_heading_error (m_heading_error),
        .m_in_deadband   (m_in_deadband),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 19);
    end

    function automatic drive_res_t predict_drive(input logic [7:0] code, input logic [19:0] el);
        longint e, t, c, dt, acc, sum, lim_hi, lim_lo, gp, gd, gi, mn, mxd, mxs;
        drive_res_t r;
        t = cfg_target;
        c = code;
        dt = el;
        gp = cfg_kp;
        gd = cfg_kd;
        gi = cfg_ki;
        mn = cfg_min;
        mxd = cfg_max_drive;
        mxs = cfg_max_speed;
        e = t - 2 * c;
        if (e > 180) begin
            e -= 360;
        end else if (e < -180) begin
            e += 360;
        end
        lim_hi = (longint'(1) <<< (hpd_pkg::INTEG_W - 1)) - 1;
        lim_lo = -lim_hi - 1;
        acc = integ_sum + (e * dt) / 1000;
        if (acc > lim_hi) acc = lim_hi;
        if (acc < lim_lo) acc = lim_lo;
        integ_sum = acc;
        sum = (e * gp + (e - prev_error) * gd + integ_sum * gi) / 256;
        r.in_deadband = (e < 2 && e > -2);
        if (r.in_deadband) begin
            sum = 0;
            integ_sum = 0;
        end else if (sum > 0 && sum < mn) begin
            sum = mn;
        end else if (sum < 0 && sum > -mn) begin
            sum = -mn;
        end
        prev_error = e;
        sum = (sum > mxd) ? mxd : ((sum < -mxd) ? -mxd : sum);
        sum = (sum > mxs) ? mxs : ((sum < -mxs) ? -mxs : sum);
        r.drive = sum[10:0];
        r.heading_error = e[8:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        drive_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction, heading_error", m_heading_error, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_drive !== want.drive)
                    report_mismatch("drive", m_drive, want.drive);
                if (m_heading_error !== want.heading_error)
                    report_mismatch("heading_error", m_heading_error, want.heading_error);
                if (m_in_deadband !== want.in_deadband)
                    report_mismatch("in_deadband", m_in_deadband, want.in_deadband);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_heading(input logic [7:0] code, input logic [19:0] el);
        while (!steady && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_heading_code <= code;
        s_elapsed_us <= el;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_drive(code, el));
    endtask

    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            hpd_pkg::CFG_TARGET:    cfg_target = data[8:0];
            hpd_pkg::CFG_GAIN_P:    cfg_kp = data;
            hpd_pkg::CFG_GAIN_D:    cfg_kd = data;
            hpd_pkg::CFG_GAIN_I:    cfg_ki = data;
            hpd_pkg::CFG_MIN_DRIVE: cfg_min = data[9:0];
            hpd_pkg::CFG_MAX_DRIVE: cfg_max_drive = data[9:0];
            hpd_pkg::CFG_MAX_SPEED: cfg_max_speed = data[9:0];
            default: ;
        endcase
    endtask

    task automatic apply_setup(input logic [15:0] target, input logic [15:0] kp,
                               input logic [15:0] kd, input logic [15:0] ki,
                               input logic [15:0] min_d, input logic [15:0] max_d,
                               input logic [15:0] max_s);
        wait_for_idle();
        write_reg(hpd_pkg::CFG_TARGET, target);
        write_reg(hpd_pkg::CFG_GAIN_P, kp);
        write_reg(hpd_pkg::CFG_GAIN_D, kd);
        write_reg(hpd_pkg::CFG_GAIN_I, ki);
        write_reg(hpd_pkg::CFG_MIN_DRIVE, min_d);
        write_reg(hpd_pkg::CFG_MAX_DRIVE, max_d);
        write_reg(hpd_pkg::CFG_MAX_SPEED, max_s);
        if ($urandom_range(2) == 0) write_reg(CFG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_value(input int width, input int typical);
        logic [15:0] mask;
        logic [15:0] v;
        mask = 16'((32'd1 << width) - 1);
        case ($urandom_range(9))
            0: v = '0;
            1: v = mask;
            2, 3, 4, 5: v = 16'($urandom_range(typical));
            default: v = 16'($urandom) & mask;
        endcase
        return v | (16'($urandom) & ~mask);
    endfunction

    function automatic logic [19:0] pick_elapsed();
        case ($urandom_range(3))
            0: return 20'($urandom_range(2000));
            1: return 20'($urandom);
            2: return 20'hFFFFF;
            default: return 20'($urandom_range(20));
        endcase
    endfunction

    task automatic test_reset_state();
        send_heading(8'd0, 20'd0);
        send_heading(8'd255, 20'hFFFFF);
        send_heading(8'd90, 20'd1000);
        send_heading(8'd1, 20'd0);
        send_heading(8'd128, 20'd12345);
        send_heading(8'd179, 20'd1);
        send_heading(8'd180, 20'd999);
        send_heading(8'd91, 20'd77777);
    endtask

    task automatic test_deadband();
        apply_setup(16'd101, 16'd256, 16'd512, 16'd256, 16'd0, 16'd1023, 16'd1023);
        send_heading(8'd49, 20'd3000);
        send_heading(8'd50, 20'd3000);
        send_heading(8'd49, 20'd3000);
        send_heading(8'd51, 20'd3000);
        send_heading(8'd52, 20'd3000);
        send_heading(8'd48, 20'hFFFFF);
    endtask

    task automatic test_wrap_and_clamps();
        apply_setup(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd1023, 16'd5);
        send_heading(8'd0, 20'd0);
        send_heading(8'd255, 20'd1000);
        send_heading(8'd165, 20'hFFFFF);
        apply_setup(16'd360, 16'd100, 16'd0, 16'd0, 16'd1023, 16'd7, 16'd1023);
        send_heading(8'd0, 20'd500);
        send_heading(8'd2, 20'd500);
        send_heading(8'd179, 20'd500);
        send_heading(8'd181, 20'd500);
        apply_setup(16'd100, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd1023);
        send_heading(8'd0, 20'hFFFFF);
        send_heading(8'd255, 20'hFFFFF);
        apply_setup(16'd200, 16'd3000, 16'd0, 16'd0, 16'd10, 16'd1023, 16'd0);
        send_heading(8'd0, 20'd4000);
        send_heading(8'd100, 20'd4000);
    endtask

    // The integral winds up, staying short of its clamp, then unwinds through zero to the other sign.
    task automatic test_integral_windup();
        apply_setup(16'd180, 16'd0, 16'd0, 16'd1, 16'd0, 16'd1023, 16'd1023);
        send_heading(8'd90, 20'd0);
        repeat (40) send_heading(8'd0, 20'hFFFFF);
        repeat (60) send_heading(8'd180, 20'hFFFFF);
        repeat (20) send_heading(8'd0, 20'd999);
    endtask

    task automatic test_random_traffic();
        int n_items;
        logic [7:0] code;
        for (int phase = 0; phase < 12; phase++) begin
            steady = (phase == 0);
            if (phase == 1) begin
                apply_setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            end else if (phase == 2) begin
                apply_setup(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            end else begin
                apply_setup(pick_value(9, 359), pick_value(16, 1024), pick_value(16, 2048),
                            pick_value(16, 8), pick_value(10, 64), pick_value(10, 1023),
                            pick_value(10, 1023));
            end
            n_items = 110 + $urandom_range(10);
            repeat (n_items) begin
                if ($urandom_range(3) == 0) begin
                    code = 8'(int'(cfg_target >> 1) + $urandom_range(4) - 2);
                end else begin
                    code = 8'($urandom);
                end
                send_heading(code, pick_elapsed());
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_deadband();
        test_wrap_and_clamps();
        test_integral_windup();
        test_random_traffic();
        wait_for_idle();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== heading_pid_drive.f =====
design/hpd_pkg.sv
design/hpd_mul.sv
design/heading_pid_drive.sv
dv/heading_pid_drive_tb.sv
